// ----- rtl/core/pedd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedd_pkg
// Shared types, codes and arithmetic helpers for the palette dither core.
// ----------------------------------------------------------------------------
package pedd_pkg;

  // Input mode codes.
  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_ROW     = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DRAW_COLOUR  = 1'b0;
  localparam logic REG_PALETTE_SIZE = 1'b1;

  // Floyd-Steinberg weights in sixteenths.
  localparam int W_RIGHT       = 7;
  localparam int W_BELOW_RIGHT = 1;
  localparam int W_BELOW_LEFT  = 3;
  localparam int W_BELOW       = 5;

  localparam int ERR_MAX = 511;
  localparam int ERR_MIN = -512;
  localparam int CHAN_MAX = 255;

  localparam int CMD_DEPTH = 4;

  typedef logic signed [9:0] err_t;
  typedef logic signed [8:0] diff_t;

  typedef enum logic [1:0] {
    CMD_PIXEL,
    CMD_PALETTE,
    CMD_ROW
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  old_index;
    logic        last;
    logic [3:0]  slot;
    logic [23:0] colour;
  } cmd_t;

  // Saturate a widened error sum to the stored ten-bit range.
  function automatic err_t sat10(input logic signed [11:0] v);
    err_t r;
    if (v > 12'(ERR_MAX)) begin
      r = 10'(ERR_MAX);
    end else if (v < 12'(ERR_MIN)) begin
      r = 10'(ERR_MIN);
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Weighted share of an error, truncated towards zero.
  function automatic err_t share(input diff_t e, input logic [2:0] w);
    logic signed [12:0] p;
    logic signed [12:0] q;
    p = 13'(e) * $signed({10'd0, w});
    if (p < 0) begin
      q = -((-p) >>> 4);
    end else begin
      q = p >>> 4;
    end
    return q[9:0];
  endfunction

endpackage

// ----- rtl/core/pedd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedd_cmd_fifo
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module pedd_cmd_fifo
  import pedd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(CMD_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push && !full) - (PTR_W + 1)'(pop && !empty);
    end
  end

endmodule

// ----- rtl/core/pedd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedd_front
// Accepts input words, classifies them by mode and queues commands.
// ----------------------------------------------------------------------------
module pedd_front
  import pedd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  old_index,
  input  logic [3:0]  palette_slot,
  input  logic [23:0] palette_colour,
  input  logic        last_in_span,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        full
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      accept;
  logic      keep;
  cmd_kind_t kind;

  assign in_stall = cmd_valid && full;
  assign accept   = in_valid && !in_stall;
  assign push     = cmd_valid && !full;
  assign push_cmd = cmd;

  // Unused mode codes are accepted and dropped here.
  always_comb begin
    keep = 1'b1;
    kind = CMD_PIXEL;
    case (mode)
      MODE_PIXEL:   kind = CMD_PIXEL;
      MODE_PALETTE: kind = CMD_PALETTE;
      MODE_ROW:     kind = CMD_ROW;
      default:      keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= (cmd_valid && !push) || (accept && keep);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cmd.kind      <= kind;
      cmd.old_index <= old_index;
      cmd.last      <= last_in_span;
      cmd.slot      <= palette_slot;
      cmd.colour    <= palette_colour;
    end
  end

endmodule

// ----- rtl/core/pedd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedd_back
// Executes queued commands: palette writes, row starts and pixel dithering.
// ----------------------------------------------------------------------------
module pedd_back
  import pedd_pkg::*;
#(
  parameter int LINE_WIDTH      = 256,
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  input  logic        cfg_write,
  input  logic        cfg_sel,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  new_index,
  output logic        last_out
);

  localparam int PW  = $clog2(LINE_WIDTH);
  localparam int AW  = PW + 1;
  localparam int PSW = $clog2(LINE_WIDTH + 1);
  localparam int PIW = $clog2(PALETTE_ENTRIES);
  localparam int CW  = PIW + 1;
  localparam logic [PSW-1:0] POS_END  = PSW'(LINE_WIDTH);
  localparam logic [PSW-1:0] POS_LAST = PSW'(LINE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_BLEND, S_SEARCH,
    S_CHAIN, S_FLUSH, S_ROW_F1, S_ROW_F2, S_EMIT
  } state_t;

  state_t state;

  // Two error rows and the palette, each with one registered read port.
  logic [29:0] err_mem [2**AW];
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [29:0] err_rdata;
  logic [23:0] pal_rdata;

  logic          err_we;
  logic [AW-1:0] err_waddr;
  logic [29:0]   err_wdata;
  logic [AW-1:0] err_raddr;
  logic          pal_we;
  logic [PIW-1:0] pal_raddr;

  logic [31:0]    draw_colour;
  logic [4:0]     palette_size;
  logic           parity;
  logic [PSW-1:0] pos;
  logic           clr_all;
  logic [AW-1:0]  clr_cnt;
  logic [PW-1:0]  col;
  logic           last_r;
  logic           in_last_r;
  logic [3:0]     old_idx_r;
  logic           old_oob;
  logic           passthru;
  logic [PIW-1:0] k;
  logic [PIW-1:0] near_idx;
  logic [17:0]    best;

  err_t        carry7  [3];
  err_t        pend_a  [3];
  err_t        pend_b  [3];
  err_t        cur_err [3];
  diff_t       err_v   [3];
  logic [15:0] prod_d  [3];
  logic [15:0] prod_o  [3];
  logic [7:0]  d       [3];

  // Combinational per-channel values.
  logic [7:0]         oc_ch   [3];
  err_t               carry_e [3];
  err_t               rd_err  [3];
  diff_t              e_ch    [3];
  logic signed [17:0] sq      [3];
  logic [17:0]        sq_sum;
  logic signed [11:0] bsum    [3];
  err_t               s7 [3];
  err_t               s5 [3];
  err_t               s3 [3];
  err_t               s1 [3];
  err_t               pa_out  [3];
  err_t               pa_next [3];
  logic [CW-1:0]      count;
  logic [7:0]         alpha;

  assign alpha = draw_colour[7:0];
  assign pop   = (state == S_IDLE) && !empty;

  always_comb begin
    if (palette_size == 5'd0) begin
      count = CW'(1);
    end else if (palette_size > 5'(PALETTE_ENTRIES)) begin
      count = CW'(PALETTE_ENTRIES);
    end else begin
      count = CW'(palette_size);
    end
  end

  always_comb begin
    sq_sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      oc_ch[ch]   = old_oob ? 8'd0 : pal_rdata[23 - 8*ch -: 8];
      carry_e[ch] = (col == '0) ? err_t'(0) : carry7[ch];
      rd_err[ch]  = err_rdata[29 - 10*ch -: 10];
      e_ch[ch]    = $signed({1'b0, d[ch]}) - $signed({1'b0, pal_rdata[23 - 8*ch -: 8]});
      sq[ch]      = e_ch[ch] * e_ch[ch];
      sq_sum      = sq_sum + $unsigned(sq[ch]);
      bsum[ch]    = $signed({4'd0, div255(prod_d[ch])}) + $signed({4'd0, div255(prod_o[ch])})
                  + 12'(cur_err[ch]);
      s7[ch]      = share(err_v[ch], 3'(W_RIGHT));
      s5[ch]      = share(err_v[ch], 3'(W_BELOW));
      s3[ch]      = share(err_v[ch], 3'(W_BELOW_LEFT));
      s1[ch]      = share(err_v[ch], 3'(W_BELOW_RIGHT));
      pa_out[ch]  = sat10(12'(pend_a[ch]) + 12'(s3[ch]));
      pa_next[ch] = sat10(12'((col == '0) ? err_t'(0) : pend_b[ch]) + 12'(s5[ch]));
    end
  end

  // Error memory write port: clearing sweeps and deferred next-row writes.
  always_comb begin
    err_we    = 1'b0;
    err_waddr = '0;
    err_wdata = '0;
    case (state)
      S_CLEAR: begin
        err_we    = 1'b1;
        err_waddr = clr_all ? clr_cnt : {parity, clr_cnt[PW-1:0]};
      end
      S_CHAIN: begin
        err_we    = (col != '0);
        err_waddr = {parity, col - PW'(1)};
        err_wdata = {pa_out[0], pa_out[1], pa_out[2]};
      end
      S_FLUSH: begin
        err_we    = 1'b1;
        err_waddr = {parity, col};
        err_wdata = {pend_a[0], pend_a[1], pend_a[2]};
      end
      S_ROW_F1: begin
        err_we    = 1'b1;
        err_waddr = {parity, pos[PW-1:0] - PW'(1)};
        err_wdata = {pend_a[0], pend_a[1], pend_a[2]};
      end
      S_ROW_F2: begin
        err_we    = 1'b1;
        err_waddr = {parity, pos[PW-1:0]};
        err_wdata = {pend_b[0], pend_b[1], pend_b[2]};
      end
      default: err_we = 1'b0;
    endcase
  end

  assign err_raddr = {~parity, pos[PW-1:0]};
  assign pal_we    = pop && (head.kind == CMD_PALETTE) && ({1'b0, head.slot} < 5'(PALETTE_ENTRIES));

  always_comb begin
    case (state)
      S_BLEND:  pal_raddr = '0;
      S_SEARCH: pal_raddr = k + PIW'(1);
      default:  pal_raddr = head.old_index[PIW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (err_we) begin
      err_mem[err_waddr] <= err_wdata;
    end
    err_rdata <= err_mem[err_raddr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[head.slot[PIW-1:0]] <= head.colour;
    end
    pal_rdata <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_colour  <= '0;
      palette_size <= 5'd16;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_DRAW_COLOUR:  draw_colour  <= cfg_wdata;
        REG_PALETTE_SIZE: palette_size <= cfg_wdata[4:0];
        default:          draw_colour  <= draw_colour;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_all   <= 1'b1;
      clr_cnt   <= '0;
      parity    <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_all ? (clr_cnt == '1) : (clr_cnt[PW-1:0] == PW'(LINE_WIDTH - 1))) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            case (head.kind)
              CMD_PIXEL: begin
                col       <= pos[PW-1:0];
                last_r    <= head.last || (pos == POS_LAST);
                in_last_r <= head.last;
                old_idx_r <= head.old_index;
                old_oob   <= {1'b0, head.old_index} >= 5'(PALETTE_ENTRIES);
                passthru  <= (pos == POS_END) || (alpha == 8'd0);
                if (pos == POS_END) begin
                  state <= S_EMIT;
                end else if (alpha == 8'd0) begin
                  for (int ch = 0; ch < 3; ch++) begin
                    err_v[ch] <= '0;
                  end
                  state <= S_CHAIN;
                end else begin
                  state <= S_LOOKUP;
                end
              end
              CMD_ROW: begin
                if (pos != '0 && pos != POS_END) begin
                  state <= S_ROW_F1;
                end else begin
                  parity  <= ~parity;
                  pos     <= '0;
                  clr_all <= 1'b0;
                  clr_cnt <= '0;
                  state   <= S_CLEAR;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOOKUP: begin
          for (int ch = 0; ch < 3; ch++) begin
            prod_o[ch]  <= oc_ch[ch] * (8'(CHAN_MAX) - alpha);
            prod_d[ch]  <= draw_colour[31 - 8*ch -: 8] * alpha;
            cur_err[ch] <= sat10(12'(rd_err[ch]) + 12'(carry_e[ch]));
          end
          state <= S_BLEND;
        end
        S_BLEND: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (bsum[ch] > 12'(CHAN_MAX)) begin
              d[ch] <= 8'(CHAN_MAX);
            end else if (bsum[ch] < 0) begin
              d[ch] <= 8'd0;
            end else begin
              d[ch] <= bsum[ch][7:0];
            end
          end
          best  <= '1;
          k     <= '0;
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (sq_sum < best) begin
            best     <= sq_sum;
            near_idx <= k;
            for (int ch = 0; ch < 3; ch++) begin
              err_v[ch] <= e_ch[ch];
            end
          end
          k <= k + PIW'(1);
          if ({1'b0, k} == count - CW'(1)) begin
            state <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          for (int ch = 0; ch < 3; ch++) begin
            pend_a[ch] <= pa_next[ch];
            pend_b[ch] <= s1[ch];
            carry7[ch] <= s7[ch];
          end
          pos   <= last_r ? POS_END : pos + PSW'(1);
          state <= last_r ? S_FLUSH : S_EMIT;
        end
        S_FLUSH: state <= S_EMIT;
        S_ROW_F1: state <= S_ROW_F2;
        S_ROW_F2: begin
          parity  <= ~parity;
          pos     <= '0;
          clr_all <= 1'b0;
          clr_cnt <= '0;
          state   <= S_CLEAR;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            new_index <= passthru ? old_idx_r : 4'(near_idx);
            last_out  <= passthru ? in_last_r : last_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Deferred writes only ever land in the row that collects next-row errors.
  a_next_row_only: assert property (@(posedge clk) disable iff (rst)
    err_we && !(state == S_CLEAR && clr_all) |-> err_waddr[PW] == parity)
    else $error("error write outside the next row");

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_END)
    else $error("pixel position beyond the line");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> {1'b0, k} < count)
    else $error("palette search past the configured size");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_valid && out_stall |=> state == S_EMIT)
    else $error("result produced over a pending word");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE || $past(head.kind) == CMD_PALETTE)
    else $error("pixel or row command did not leave idle");

endmodule

// ----- rtl/core/palette_error_diffusion_dither_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_core
// Floyd-Steinberg dither of palette-index pixels with an alpha-blended colour.
// ----------------------------------------------------------------------------
// Usage. Input words (mode, old_index, palette_slot, palette_colour,
// last_in_span) are taken on in_valid while in_stall is low. Mode 0 is a
// pixel and yields one output word (new_index, last_out); mode 1 writes a
// palette entry; mode 2 starts a new row; mode 3 is discarded. Output words
// leave on out_valid and wait, unchanged, while out_stall is high; the back
// end then holds and the queue fills until in_stall rises.
// Configuration (draw colour, palette size) is written through cfg_valid /
// cfg_ready with cfg_index and cfg_data; the user writes it only while the
// block is idle, and the block itself does not enforce this.
// Timing. A front register and a four-entry command queue decouple input
// from execution. The palette search of a dithered pixel in the back end
// compares one entry per cycle through the single palette read port; a
// pixel that ends the span adds a flush step before its output word.
// Pixels past the span end go straight to output, zero-alpha pixels skip
// lookup, blend and search, and palette writes finish in the idle state.
// Reset clears both error rows in one sweep over all 2 * 2**clog2(LINE_WIDTH)
// entries (512 by default); a row start clears the LINE_WIDTH entries of the
// new next row. No command executes during a sweep; words still queue.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_core
  import pedd_pkg::*;
#(
  parameter int LINE_WIDTH      = 256,
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  old_index,
  input  logic [3:0]  palette_slot,
  input  logic [23:0] palette_colour,
  input  logic        last_in_span,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  new_index,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  // The user writes registers only while idle; the block does not enforce this, so the port never holds off.
  assign cfg_ready = 1'b1;

  pedd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .old_index      (old_index),
    .palette_slot   (palette_slot),
    .palette_colour (palette_colour),
    .last_in_span   (last_in_span),
    .push           (push),
    .push_cmd       (push_cmd),
    .full           (full)
  );

  pedd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // The back end owns the palette, both error rows and the output register.
  pedd_back #(
    .LINE_WIDTH      (LINE_WIDTH),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_index (new_index),
    .last_out  (last_out)
  );

endmodule

// ----- tb/sv/tb_palette_error_diffusion_dither_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_error_diffusion_dither_core
// Self-checking testbench for the palette error-diffusion dither core.
// ----------------------------------------------------------------------------
// A behavioural predictor keeps its own palette, error rows, row parity and
// span position. It works out the expected output word for each accepted
// pixel word. A monitor compares every accepted output word, field by field,
// with the oldest prediction. The stimulus starts with directed tests: the
// palette load, pass-through at zero alpha, field extremes, mode 3 and the
// span-end clamp. Random phases follow, each with its own draw colour,
// palette size and idling pattern. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_palette_error_diffusion_dither_core;
  import pedd_pkg::*;

  localparam int          LINE_W       = 256;
  localparam int          PAL_N        = 16;
  localparam logic [1:0]  MODE_IGNORED = 2'd3;
  localparam int          CYCLE_LIMIT  = 1500000;
  // Drain time for words that produce no output, such as row starts, whose
  // clearing sweeps may still run behind a few queued commands.
  localparam int          DRAIN_CYCLES = 1500;
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          PHASES       = 12;

  typedef struct {
    logic [3:0] index;
    logic       last;
  } pixel_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [3:0]  old_index;
  logic [3:0]  palette_slot;
  logic [23:0] palette_colour;
  logic        last_in_span;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  new_index;
  logic        last_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // The predictor's own copy of the block state.
  int          carried_err[2][LINE_W][3];
  logic [23:0] palette[PAL_N];
  logic        parity;
  int          span_pos;
  logic [31:0] draw_colour;
  logic [4:0]  search_size;

  pixel_result_t pending_results[$];

  int   mismatches;
  int   cycles;
  int   words_sent;
  int   pixels_sent;
  int   results_checked;
  int   rows_started;
  logic calm;

  palette_error_diffusion_dither_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .old_index      (old_index),
    .palette_slot   (palette_slot),
    .palette_colour (palette_colour),
    .last_in_span   (last_in_span),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_index      (new_index),
    .last_out       (last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The watchdog ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("palette_error_diffusion_dither_core: mismatch");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("[%0t] %s", $realtime, what);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one, and none in a calm phase.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int sat_err(input int v);
    if (v > ERR_MAX) begin
      return ERR_MAX;
    end else if (v < ERR_MIN) begin
      return ERR_MIN;
    end
    return v;
  endfunction

  // Adds a weighted share of the error to one stored entry. Integer division
  // truncates toward zero, as the shares must.
  task automatic diffuse(input int row, input int at, input int e[3], input int w);
    for (int ch = 0; ch < 3; ch++) begin
      carried_err[row][at][ch] = sat_err(carried_err[row][at][ch] + (w * e[ch]) / 16);
    end
  endtask

  // Updates the predicted state for one accepted word and queues the
  // expected output word of a pixel.
  task automatic predict_dither(input logic [1:0] m, input logic [3:0] oi,
                                input logic [3:0] slot, input logic [23:0] colour,
                                input logic li);
    int alpha;
    int target[3];
    int e[3];
    int best_err[3];
    int best_sum;
    int sum;
    int near_idx;
    int count;
    int cur;
    int nxt;
    int v;
    logic last;
    pixel_result_t r;
    alpha = draw_colour[7:0];
    case (m)
      MODE_PALETTE: begin
        palette[slot] = colour;
      end
      MODE_ROW: begin
        parity = ~parity;
        for (int p = 0; p < LINE_W; p++) begin
          for (int ch = 0; ch < 3; ch++) begin
            carried_err[parity][p][ch] = 0;
          end
        end
        span_pos = 0;
      end
      MODE_PIXEL: begin
        if (alpha == 0 || span_pos >= LINE_W) begin
          // Pass-through: the pixel keeps its index and no error moves.
          r.index = oi;
          r.last  = li;
          if (span_pos < LINE_W) begin
            span_pos = (li || span_pos == LINE_W - 1) ? LINE_W : span_pos + 1;
          end
        end else begin
          last = li || span_pos == LINE_W - 1;
          nxt  = parity;
          cur  = 1 - nxt;
          for (int ch = 0; ch < 3; ch++) begin
            v = (int'(draw_colour[31 - 8 * ch -: 8]) * alpha) / CHAN_MAX
              + (int'(palette[oi][23 - 8 * ch -: 8]) * (CHAN_MAX - alpha)) / CHAN_MAX
              + carried_err[cur][span_pos][ch];
            target[ch] = v > CHAN_MAX ? CHAN_MAX : (v < 0 ? 0 : v);
          end
          count = search_size == 0 ? 1 : (search_size > PAL_N ? PAL_N : search_size);
          best_sum = 32'h7fffffff;
          near_idx = 0;
          best_err = '{0, 0, 0};
          // The first minimum wins, so a later entry must be strictly nearer.
          for (int n = 0; n < count; n++) begin
            sum = 0;
            for (int ch = 0; ch < 3; ch++) begin
              e[ch] = target[ch] - int'(palette[n][23 - 8 * ch -: 8]);
              sum += e[ch] * e[ch];
            end
            if (sum < best_sum) begin
              best_sum = sum;
              near_idx = n;
              best_err = e;
            end
          end
          if (!last) begin
            diffuse(cur, span_pos + 1, best_err, W_RIGHT);
            diffuse(nxt, span_pos + 1, best_err, W_BELOW_RIGHT);
          end
          if (span_pos > 0) begin
            diffuse(nxt, span_pos - 1, best_err, W_BELOW_LEFT);
          end
          diffuse(nxt, span_pos, best_err, W_BELOW);
          span_pos = last ? LINE_W : span_pos + 1;
          r.index  = near_idx[3:0];
          r.last   = last;
        end
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // Sends one input word and waits for it to be taken. Valid stays high into
  // the next word when no gap follows.
  task automatic send_word(input logic [1:0] m, input logic [3:0] oi,
                           input logic [3:0] slot, input logic [23:0] colour,
                           input logic li);
    int g;
    @(negedge clk);
    in_valid       = 1'b1;
    mode           = m;
    old_index      = oi;
    palette_slot   = slot;
    palette_colour = colour;
    last_in_span   = li;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_dither(m, oi, slot, colour, li);
    words_sent++;
    if (m == MODE_PIXEL) begin
      pixels_sent++;
    end
    if (m == MODE_ROW) begin
      rows_started++;
    end
    g = gap_length();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_pixel(input logic [3:0] oi, input logic li);
    send_word(MODE_PIXEL, oi, 4'($urandom), 24'($urandom), li);
  endtask

  task automatic send_row_start();
    send_word(MODE_ROW, 4'($urandom), 4'($urandom), 24'($urandom), 1'($urandom));
  endtask

  // Lets every expected word arrive and the back end settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (idx == REG_DRAW_COLOUR) begin
      draw_colour = data;
    end else begin
      search_size = data[4:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [31:0] colour, input logic [4:0] size);
    wait_idle();
    write_register(REG_DRAW_COLOUR, colour);
    write_register(REG_PALETTE_SIZE, {27'd0, size});
  endtask

  // Every entry is written before any pixel, so no unwritten entry is ever
  // read. Entries 14 and 15 repeat 0 and 1 to exercise the tie rule.
  task automatic test_palette_load();
    send_word(MODE_PALETTE, 4'd0, 4'd0, 24'h000000, 1'b0);
    send_word(MODE_PALETTE, 4'd15, 4'd1, 24'hffffff, 1'b1);
    for (int s = 2; s < 14; s++) begin
      send_word(MODE_PALETTE, 4'($urandom), 4'(s), 24'($urandom), 1'($urandom));
    end
    send_word(MODE_PALETTE, 4'd3, 4'd14, 24'h000000, 1'b0);
    send_word(MODE_PALETTE, 4'd7, 4'd15, 24'hffffff, 1'b0);
  endtask

  // With reset's zero alpha every pixel passes unchanged; mode 3 is dropped.
  task automatic test_zero_alpha();
    send_row_start();
    send_pixel(4'd0, 1'b0);
    send_pixel(4'd15, 1'b0);
    send_word(MODE_IGNORED, 4'd9, 4'd9, 24'h5a5a5a, 1'b1);
    send_pixel(4'd5, 1'b1);
    send_pixel(4'd10, 1'b1);
  endtask

  // Full alpha, then the smallest and largest palette sizes.
  task automatic test_extremes();
    configure(32'hffffffff, 5'd16);
    send_row_start();
    send_pixel(4'd0, 1'b0);
    send_pixel(4'd15, 1'b0);
    send_pixel(4'd1, 1'b1);
    send_pixel(4'd2, 1'b0);
    configure(32'h00000080, 5'd1);
    send_row_start();
    send_pixel(4'd15, 1'b0);
    send_pixel(4'd0, 1'b1);
    configure(32'h12f0a701, 5'd16);
    send_row_start();
    send_pixel(4'd8, 1'b0);
    send_pixel(4'd3, 1'b1);
  endtask

  // A span that never flags its end is cut at the line width, and the words
  // after it pass through with their own end flag.
  task automatic test_span_clamp();
    configure(32'h7f3fc0c8, 5'd16);
    send_row_start();
    for (int p = 0; p < LINE_W; p++) begin
      send_pixel(4'($urandom), 1'b0);
    end
    send_pixel(4'd4, 1'b0);
    send_pixel(4'd11, 1'b1);
  endtask

  // Random phases of mostly well-formed rows with random content, sprinkled
  // with palette rewrites, ignored words and stray pixels.
  task automatic test_random_rows();
    logic [31:0] colour;
    logic [4:0]  size;
    int target;
    int len;
    int r;
    target = words_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      colour = $urandom;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        colour[7:0] = 8'h00;
      end else if (r == 1) begin
        colour[7:0] = 8'hff;
      end
      size = ph == 0 ? 5'd1 : (ph == 1 ? 5'd16 : 5'($urandom_range(1, 16)));
      configure(colour, size);
      calm = ph % 3 == 2;
      target += RANDOM_ITEMS / PHASES;
      while (words_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_row_start();
          len = $urandom_range(0, 19) == 0 ? $urandom_range(30, LINE_W + 4)
                                            : $urandom_range(1, 24);
          for (int p = 0; p < len; p++) begin
            send_pixel(4'($urandom), p == len - 1 ? 1'($urandom_range(0, 7) != 0) : 1'b0);
          end
          if ($urandom_range(0, 3) == 0) begin
            send_pixel(4'($urandom), 1'($urandom));
          end
        end else if (r < 88) begin
          send_word(MODE_PALETTE, 4'($urandom), 4'($urandom), 24'($urandom), 1'($urandom));
        end else if (r < 93) begin
          send_word(MODE_IGNORED, 4'($urandom), 4'($urandom), 24'($urandom), 1'($urandom));
        end else begin
          send_pixel(4'($urandom), 1'($urandom));
        end
      end
      calm = 1'b0;
    end
  endtask

  // The receiver stalls at random, with calm stretches where it never does.
  initial begin
    out_stall = 1'b0;
    forever begin
      int g;
      g = gap_length();
      if (g > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  // Each accepted output word is checked against the oldest prediction.
  always @(posedge clk) begin
    pixel_result_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("output word with nothing expected: index %0d last %0b",
                         new_index, last_out));
      end else begin
        exp_word = pending_results.pop_front();
        if (new_index !== exp_word.index) begin
          report($sformatf("new_index %0d, expected %0d", new_index, exp_word.index));
        end
        if (last_out !== exp_word.last) begin
          report($sformatf("last_out %0b, expected %0b", last_out, exp_word.last));
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    mode            = MODE_PIXEL;
    old_index       = 4'd0;
    palette_slot    = 4'd0;
    palette_colour  = 24'd0;
    last_in_span    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_DRAW_COLOUR;
    cfg_data        = 32'd0;
    calm            = 1'b0;
    mismatches      = 0;
    cycles          = 0;
    words_sent      = 0;
    pixels_sent     = 0;
    results_checked = 0;
    rows_started    = 0;
    parity          = 1'b0;
    span_pos        = 0;
    draw_colour     = 32'd0;
    search_size     = 5'd16;
    for (int n = 0; n < PAL_N; n++) begin
      palette[n] = 24'd0;
    end
    for (int p = 0; p < LINE_W; p++) begin
      for (int ch = 0; ch < 3; ch++) begin
        carried_err[0][p][ch] = 0;
        carried_err[1][p][ch] = 0;
      end
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_palette_load();
    test_zero_alpha();
    test_extremes();
    test_span_clamp();
    test_random_rows();

    wait_idle();
    $display("Sent %0d words (%0d pixels, %0d row starts) and checked %0d output words,",
             words_sent, pixels_sent, rows_started, results_checked);
    $display("over several draw colours and palette sizes from 1 to 16.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("palette_error_diffusion_dither_core: match");
    end else begin
      $display("%0d mismatches, %0d predictions left over", mismatches,
               pending_results.size());
      $display("palette_error_diffusion_dither_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pedd_pkg.sv
rtl/core/pedd_cmd_fifo.sv
rtl/core/pedd_front.sv
rtl/core/pedd_back.sv
rtl/core/palette_error_diffusion_dither_core.sv
tb/sv/tb_palette_error_diffusion_dither_core.sv
